// ===== rtl/sbsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_pkg
// Algorithm codes, seeds and shift amounts for the selectable byte stream
// hash unit.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [1:0]  alg_t;
    typedef logic [7:0]  byte_t;
    typedef logic [31:0] hash_t;

    localparam alg_t ALG_PJW   = 2'd0;
    localparam alg_t ALG_DJB2  = 2'd1;
    localparam alg_t ALG_SDBM  = 2'd2;
    localparam alg_t ALG_SHIFT = 2'd3;

    localparam alg_t ALG_RESET = ALG_DJB2;

    localparam hash_t DJB_SEED  = 32'd5381;
    localparam hash_t ZERO_SEED = 32'd0;

    localparam int DJB_SHIFT     = 5;
    localparam int SDBM_SHIFT_LO = 6;
    localparam int SDBM_SHIFT_HI = 16;
    localparam int SHIFT_ONE     = 1;
    localparam int PJW_SHIFT     = 4;
    localparam int PJW_FOLD      = 24;

    localparam hash_t PJW_KEEP = 32'h0FFF_FFFF;

    function automatic hash_t seed_of(input alg_t alg);
        return (alg == ALG_DJB2) ? DJB_SEED : ZERO_SEED;
    endfunction

endpackage

// ===== rtl/sbsh_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_step
// One hash update: folds a byte into the running value with the selected
// algorithm. Pure combinational logic.
// ----------------------------------------------------------------------------
module sbsh_step (
    input  sbsh_pkg::alg_t  alg,
    input  sbsh_pkg::hash_t hash_in,
    input  sbsh_pkg::byte_t data_in,
    output sbsh_pkg::hash_t hash_out
);
    import sbsh_pkg::*;

    hash_t byte_ext;
    hash_t pjw_sum;

    assign byte_ext = {24'd0, data_in};
    assign pjw_sum  = (hash_in << PJW_SHIFT) + byte_ext;

    always_comb begin
        case (alg)
            ALG_PJW: begin
                hash_out = (pjw_sum ^ {24'd0, pjw_sum[31:28], 4'd0}) & PJW_KEEP;
            end
            ALG_DJB2: begin
                hash_out = (hash_in + (hash_in << DJB_SHIFT)) ^ byte_ext;
            end
            ALG_SDBM: begin
                hash_out = byte_ext + (hash_in << SDBM_SHIFT_LO)
                         + (hash_in << SDBM_SHIFT_HI) - hash_in;
            end
            default: begin
                hash_out = (hash_in << SHIFT_ONE) ^ byte_ext;
            end
        endcase
    end

endmodule

// ===== rtl/selectable_byte_stream_hash_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_byte_stream_hash_unit
// Byte stream hash with four selectable algorithms (PJW, DJB2 xor, SDBM,
// shift-one xor). Emits the hash on the last byte of each message.
// A byte is held in the input register, and the hash of a last byte in the output register.
// Throughput: one byte per cycle while no last byte is stalled (see below).
// A last byte holds in the input register while the output register is full
// and not taken.
// Reset: algorithm returns to DJB2, no message in progress, both registers empty.
// ----------------------------------------------------------------------------
module selectable_byte_stream_hash_unit (
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  sbsh_pkg::alg_t  cfg_data,

    input  logic            s_valid,
    output logic            s_ready,
    input  sbsh_pkg::byte_t s_data_byte,
    input  logic            s_last_byte,

    output logic            m_valid,
    input  logic            m_ready,
    output sbsh_pkg::hash_t m_digest
);
    import sbsh_pkg::*;

    alg_t  alg_reg;
    hash_t acc_reg,  acc_next;
    logic  mid_reg,  mid_next;

    logic  in_valid_reg, in_valid_next;
    byte_t in_byte_reg;
    logic  in_last_reg;

    logic  out_valid_reg, out_valid_next;
    hash_t out_hash_reg;

    hash_t start_hash;
    hash_t step_hash;
    logic  in_fire;
    logic  out_load;

    assign cfg_ready = 1'b1;

    // advance the input register unless a last byte is blocked by a full output
    assign in_fire  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign out_load = in_fire && in_last_reg;
    assign s_ready  = !in_valid_reg || in_fire;

    assign start_hash = mid_reg ? acc_reg : seed_of(alg_reg);

    sbsh_step u_step (
        .alg      (alg_reg),
        .hash_in  (start_hash),
        .data_in  (in_byte_reg),
        .hash_out (step_hash)
    );

    always_comb begin
        acc_next       = acc_reg;
        mid_next       = mid_reg;
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_fire) begin
            acc_next      = step_hash;
            mid_next      = !in_last_reg;
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg       <= ALG_RESET;
            mid_reg       <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                alg_reg <= cfg_data;
            end
            mid_reg       <= mid_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (out_load) begin
            out_hash_reg <= step_hash;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_digest = out_hash_reg;

    a_last_ends_message: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last_reg |=> !mid_reg)
        else $error("message still open after last byte");

    a_byte_opens_message: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !in_last_reg |=> mid_reg)
        else $error("message not open after non-last byte");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_fire && in_last_reg))
        else $error("result appeared without a last byte");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_fire |-> in_last_reg && m_valid && !m_ready)
        else $error("input register stalled with room downstream");

endmodule

// ===== tb/sv/selectable_byte_stream_hash_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_byte_stream_hash_unit_tb
// Streams byte messages through the hash unit under all four algorithms.
// A queue-fed driver offers bytes with random gaps, and a clocked monitor
// takes results with random back-pressure, including one long hold-off.
// Each accepted byte updates a local copy of the accumulator, and every
// finished message queues its expected hash. The algorithm register is
// rewritten between phases, both between messages and in the middle of one.
// ----------------------------------------------------------------------------
module selectable_byte_stream_hash_unit_tb;

    import sbsh_pkg::*;

    typedef struct packed {
        byte_t data;
        logic  last;
    } byte_item_t;

    logic   aclk         = 1'b0;
    logic   aresetn      = 1'b0;
    logic   cfg_valid    = 1'b0;
    logic   cfg_ready;
    alg_t   cfg_data     = ALG_RESET;
    logic   s_valid      = 1'b0;
    logic   s_ready;
    byte_t  s_data_byte  = '0;
    logic   s_last_byte  = 1'b0;
    logic   m_valid;
    logic   m_ready      = 1'b0;
    hash_t  m_digest;

    byte_item_t pending_bytes[$];
    hash_t      expected_hashes[$];

    alg_t   model_alg  = ALG_RESET;
    hash_t  model_acc  = DJB_SEED;
    logic   model_mid  = 1'b0;

    int     mismatch_count = 0;
    logic   calm           = 1'b0;
    int     stall_requests = 0;
    int     stall_served   = 0;

    logic   sending   = 1'b0;
    int     send_gap  = 0;
    int     take_gap  = 0;
    int     hold_left = 0;

    selectable_byte_stream_hash_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digest     (m_digest)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic hash_t seed_value(input alg_t alg);
        if (alg == ALG_DJB2) begin
            return DJB_SEED;
        end
        return ZERO_SEED;
    endfunction

    function automatic hash_t next_hash(input alg_t alg, input hash_t h, input byte_t b);
        hash_t acc;
        hash_t top;
        acc = h;
        case (alg)
            ALG_PJW: begin
                acc = (acc << PJW_SHIFT) + {24'd0, b};
                top = acc & ~PJW_KEEP;
                if (top != '0) begin
                    acc = (acc ^ (top >> PJW_FOLD)) & PJW_KEEP;
                end
            end
            ALG_DJB2: begin
                acc = (acc + (acc << DJB_SHIFT)) ^ {24'd0, b};
            end
            ALG_SDBM: begin
                acc = {24'd0, b} + (acc << SDBM_SHIFT_LO) + (acc << SDBM_SHIFT_HI) - acc;
            end
            default: begin
                acc = (acc << SHIFT_ONE) ^ {24'd0, b};
            end
        endcase
        return acc;
    endfunction

    task automatic advance_hash(input byte_t b, input logic last);
        hash_t h;
        h = model_mid ? model_acc : seed_value(model_alg);
        h = next_hash(model_alg, h, b);
        if (last) begin
            expected_hashes.push_back(h);
            model_acc = seed_value(model_alg);
            model_mid = 1'b0;
        end else begin
            model_acc = h;
            model_mid = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_byte(input byte_t b, input logic last);
        byte_item_t it;
        it.data = b;
        it.last = last;
        pending_bytes.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || sending || expected_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_algorithm(input alg_t alg);
        cfg_data  <= alg;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_alg = alg;
        if (!model_mid) begin
            model_acc = seed_value(alg);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        byte_item_t it;
        if (!aresetn) begin
            sending  = 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                advance_hash(s_data_byte, s_last_byte);
                sending  = 1'b0;
                send_gap = calm ? 0 : $urandom_range(0, 3);
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() != 0) begin
                    it = pending_bytes.pop_front();
                    s_data_byte <= it.data;
                    s_last_byte <= it.last;
                    sending = 1'b1;
                end
            end
        end
        s_valid <= sending;
    end

    // monitor
    always @(posedge aclk) begin
        hash_t want;
        if (!aresetn) begin
            take_gap  = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash %08h", m_digest));
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_digest !== want) begin
                        report_mismatch($sformatf("digest %08h, want %08h",
                                                  m_digest, want));
                    end
                end
                take_gap = calm ? 0 : $urandom_range(0, 3);
            end else if (take_gap > 0) begin
                take_gap--;
            end
            if (stall_served != stall_requests) begin
                stall_served++;
                hold_left = 300;
            end else if (hold_left > 0) begin
                hold_left--;
            end
        end
        m_ready <= aresetn && (take_gap == 0) && (hold_left == 0);
    end

    initial begin
        int    len;
        int    count;
        int    pick;
        byte_t b;
        alg_t  alg;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset algorithm, extremes of the byte
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // pjw with top nibble fold
        write_algorithm(ALG_PJW);
        for (int i = 0; i < 8; i++) begin
            push_byte(8'hFF, i == 7);
        end
        push_byte(8'h80, 1'b1);
        wait_idle();

        write_algorithm(ALG_SDBM);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_idle();

        // switch algorithm in the middle of a message
        write_algorithm(ALG_SHIFT);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        wait_idle();
        write_algorithm(ALG_DJB2);
        push_byte(8'h03, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 11; phase++) begin
            alg = (phase < 4) ? alg_t'(phase) : alg_t'($urandom_range(0, 3));
            write_algorithm(alg);
            calm <= (phase != 1) && ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                stall_requests <= stall_requests + 1;
            end
            count = 0;
            while (count < 100) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 7);
                    b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : byte_t'($urandom);
                    push_byte(b, i == len - 1);
                end
                count += len;
            end
            // leave a message open across the next register write
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    push_byte(byte_t'($urandom), 1'b0);
                end
            end
            wait_idle();
        end

        write_algorithm(ALG_SHIFT);
        push_byte(byte_t'($urandom), 1'b1);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TIMEOUT: pending %0d, expected %0d",
                 pending_bytes.size(), expected_hashes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sbsh_pkg.sv
rtl/sbsh_step.sv
rtl/selectable_byte_stream_hash_unit.sv
tb/sv/selectable_byte_stream_hash_unit_tb.sv
